// ===== src/pv2hp_pkg.sv =====
`timescale 1ns / 1ps

package pv2hp_pkg;

   // parse phase of the current connection
   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DATA    = 2'd2,
      PH_FAILED  = 2'd3
   } phase_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_BAD_SIGNATURE = 2'd1,
      ST_BAD_COMMAND   = 2'd2,
      ST_TOO_SHORT     = 2'd3
   } status_type;

   // fixed header layout
   localparam int         SIG_LEN    = 12;
   localparam int         BUF_DEPTH  = 36;
   localparam logic [3:0] CMD_IDX    = 4'd12;
   localparam logic [3:0] FAM_IDX    = 4'd13;
   localparam logic [3:0] LEN_HI_IDX = 4'd14;
   localparam logic [3:0] HDR_LAST   = 4'd15;

   // command and family codes
   localparam logic [7:0] CMD_PROXY_V2 = 8'h21;
   localparam logic [7:0] FAM_TCP4     = 8'h11;
   localparam logic [7:0] FAM_UDP4     = 8'h12;
   localparam logic [7:0] FAM_TCP6     = 8'h21;
   localparam logic [7:0] FAM_UDP6     = 8'h22;

   // minimum payload lengths per family
   localparam logic [15:0] MIN_LEN_V4 = 16'd12;
   localparam logic [15:0] MIN_LEN_V6 = 16'd36;

   // ::ffff:0:0 prefix in the low 64 bits
   localparam logic [63:0] V4_MAPPED_PREFIX = 64'h0000_FFFF_0000_0000;

   // register address bit (byte address bit 2 selects the register)
   localparam logic CSR_LOCAL_IS_IPV6 = 1'b0;

   // kept payload bytes, entry 0 is the first payload byte
   typedef logic [BUF_DEPTH-1:0][7:0] addr_buf_type;

   // one result item
   typedef struct packed {
      status_type  status;
      logic        is_data;
      logic [7:0]  out_byte;
      logic [7:0]  addr_family;
      logic [63:0] remote_addr_hi;
      logic [63:0] remote_addr_lo;
      logic [63:0] local_addr_hi;
      logic [63:0] local_addr_lo;
      logic [15:0] remote_port;
      logic [15:0] local_port;
   } rsp_type;

   // signature byte at a header position
   function automatic logic [7:0] sig_byte(input logic [3:0] idx);
      logic [7:0] v;
      case (idx)
         4'd0:    v = 8'h0D;
         4'd1:    v = 8'h0A;
         4'd2:    v = 8'h0D;
         4'd3:    v = 8'h0A;
         4'd4:    v = 8'h00;
         4'd5:    v = 8'h0D;
         4'd6:    v = 8'h0A;
         4'd7:    v = 8'h51;
         4'd8:    v = 8'h55;
         4'd9:    v = 8'h49;
         4'd10:   v = 8'h54;
         4'd11:   v = 8'h0A;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // big-endian word from up to eight kept bytes
   function automatic logic [63:0] be_bytes(input addr_buf_type b, input int start,
                                            input int count);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < count) begin
            v = {v[55:0], b[start + i]};
         end
      end
      return v;
   endfunction

endpackage

// ===== src/proxy_v2_header_parser.sv =====
`timescale 1ns / 1ps

// output: the result of a transfer is registered in the result buffer and driven on rsp_
// throughput: one byte per cycle, set by the combinational parse step between the input
//   transfer and the result register; a two-entry result buffer keeps intake going until full
// reset: synchronous, clears parse state, result buffer and local_is_ipv6;
//   the kept payload bytes are not cleared and are only read once rewritten
module proxy_v2_header_parser (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_connection,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_is_data,
   output logic [7:0]  rsp_out_byte,
   output logic [7:0]  rsp_addr_family,
   output logic [63:0] rsp_remote_addr_hi,
   output logic [63:0] rsp_remote_addr_lo,
   output logic [63:0] rsp_local_addr_hi,
   output logic [63:0] rsp_local_addr_lo,
   output logic [15:0] rsp_remote_port,
   output logic [15:0] rsp_local_port,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // parse state
   pv2hp_pkg::phase_type    phase_ff, phase_in, phase_cur;
   logic [16:0]             cnt_ff, cnt_in, cnt_cur, cnt_inc;
   logic [15:0]             len_ff, len_in, len_full, fin_len;
   logic [7:0]              cmd_ff, cmd_in;
   logic [7:0]              fam_ff, fam_in;
   logic                    sig_ok_ff, sig_ok_in, sig_ok_cur;
   pv2hp_pkg::addr_buf_type buf_ff, buf_view;
   logic                    local_is_ipv6_ff;

   // step signals
   logic             accept;
   logic [7:0]       b;
   logic [3:0]       hdr_idx;
   logic             sig_match;
   logic             buf_wr;
   logic             pay_done;
   logic             fam4, fam6, cmd_ok, too_short, fin_ok;
   pv2hp_pkg::rsp_type fin_rsp, res;
   logic             res_valid;

   // result buffer
   logic               out_v_ff, skid_v_ff;
   pv2hp_pkg::rsp_type out_ff, skid_ff;
   logic               out_free, new_res;

   assign accept = req_valid && req_ready;
   assign b      = req_data_byte;

   // a connection start restarts the header
   assign phase_cur  = req_first_of_connection ? pv2hp_pkg::PH_HEADER : phase_ff;
   assign cnt_cur    = req_first_of_connection ? 17'd0 : cnt_ff;
   assign sig_ok_cur = req_first_of_connection ? 1'b1 : sig_ok_ff;

   assign hdr_idx   = cnt_cur[3:0];
   assign sig_match = (b == pv2hp_pkg::sig_byte(hdr_idx));
   assign len_full  = {len_ff[15:8], b};
   assign cnt_inc   = cnt_cur + 17'd1;
   assign pay_done  = (cnt_inc >= {1'b0, len_ff});

   // payload byte store, merged with the byte of this transfer
   assign buf_wr = (phase_cur == pv2hp_pkg::PH_PAYLOAD) &&
                   (cnt_cur < 17'(pv2hp_pkg::BUF_DEPTH));
   always_comb begin
      for (int k = 0; k < pv2hp_pkg::BUF_DEPTH; k++) begin
         buf_view[k] = (buf_wr && (cnt_cur == 17'(k))) ? b : buf_ff[k];
      end
   end

   // header checks at the end of the payload
   assign fin_len   = (phase_cur == pv2hp_pkg::PH_HEADER) ? len_full : len_ff;
   assign fam4      = fam_ff inside {pv2hp_pkg::FAM_TCP4, pv2hp_pkg::FAM_UDP4};
   assign fam6      = fam_ff inside {pv2hp_pkg::FAM_TCP6, pv2hp_pkg::FAM_UDP6};
   assign cmd_ok    = (cmd_ff == pv2hp_pkg::CMD_PROXY_V2);
   assign too_short = (fam4 && (fin_len < pv2hp_pkg::MIN_LEN_V4)) ||
                      (fam6 && (fin_len < pv2hp_pkg::MIN_LEN_V6));
   assign fin_ok    = cmd_ok && !too_short;

   // header result with addresses in the local family
   always_comb begin
      fin_rsp = '0;
      fin_rsp.addr_family = fam_ff;
      if (!cmd_ok) begin
         fin_rsp.status = pv2hp_pkg::ST_BAD_COMMAND;
      end else if (too_short) begin
         fin_rsp.status = pv2hp_pkg::ST_TOO_SHORT;
      end else if (fam4) begin
         fin_rsp.status = pv2hp_pkg::ST_OK;
         fin_rsp.remote_addr_lo = (local_is_ipv6_ff ? pv2hp_pkg::V4_MAPPED_PREFIX : 64'd0) |
                                  pv2hp_pkg::be_bytes(buf_view, 0, 4);
         fin_rsp.local_addr_lo  = (local_is_ipv6_ff ? pv2hp_pkg::V4_MAPPED_PREFIX : 64'd0) |
                                  pv2hp_pkg::be_bytes(buf_view, 4, 4);
         fin_rsp.remote_port = 16'(pv2hp_pkg::be_bytes(buf_view, 8, 2));
         fin_rsp.local_port  = 16'(pv2hp_pkg::be_bytes(buf_view, 10, 2));
      end else if (fam6) begin
         fin_rsp.status = pv2hp_pkg::ST_OK;
         if (local_is_ipv6_ff) begin
            fin_rsp.remote_addr_hi = pv2hp_pkg::be_bytes(buf_view, 0, 8);
            fin_rsp.remote_addr_lo = pv2hp_pkg::be_bytes(buf_view, 8, 8);
            fin_rsp.local_addr_hi  = pv2hp_pkg::be_bytes(buf_view, 16, 8);
            fin_rsp.local_addr_lo  = pv2hp_pkg::be_bytes(buf_view, 24, 8);
         end
         fin_rsp.remote_port = 16'(pv2hp_pkg::be_bytes(buf_view, 32, 2));
         fin_rsp.local_port  = 16'(pv2hp_pkg::be_bytes(buf_view, 34, 2));
      end else begin
         fin_rsp.status = pv2hp_pkg::ST_OK;
      end
   end

   // next parse state
   always_comb begin
      phase_in  = phase_cur;
      cnt_in    = cnt_cur;
      len_in    = req_first_of_connection ? 16'd0 : len_ff;
      cmd_in    = req_first_of_connection ? 8'd0 : cmd_ff;
      fam_in    = req_first_of_connection ? 8'd0 : fam_ff;
      sig_ok_in = sig_ok_cur;
      case (phase_cur)
         pv2hp_pkg::PH_HEADER: begin
            case (hdr_idx) inside
               [4'd0:4'd11]: begin
                  if (!sig_match) begin
                     sig_ok_in = 1'b0;
                  end
               end
               pv2hp_pkg::CMD_IDX:    cmd_in = b;
               pv2hp_pkg::FAM_IDX:    fam_in = b;
               pv2hp_pkg::LEN_HI_IDX: len_in = {b, 8'h00};
               default:               len_in = len_full;
            endcase
            cnt_in = {13'd0, hdr_idx} + 17'd1;
            if (hdr_idx == pv2hp_pkg::HDR_LAST) begin
               if (!sig_ok_cur) begin
                  phase_in = pv2hp_pkg::PH_FAILED;
               end else begin
                  cnt_in = 17'd0;
                  if (len_full == 16'd0) begin
                     phase_in = fin_ok ? pv2hp_pkg::PH_DATA : pv2hp_pkg::PH_FAILED;
                  end else begin
                     phase_in = pv2hp_pkg::PH_PAYLOAD;
                  end
               end
            end
         end
         pv2hp_pkg::PH_PAYLOAD: begin
            cnt_in = cnt_inc;
            if (pay_done) begin
               phase_in = fin_ok ? pv2hp_pkg::PH_DATA : pv2hp_pkg::PH_FAILED;
               if (fin_ok) begin
                  cnt_in = 17'd0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // result of this step
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      case (phase_cur)
         pv2hp_pkg::PH_HEADER: begin
            if (hdr_idx == pv2hp_pkg::HDR_LAST) begin
               if (!sig_ok_cur) begin
                  res_valid       = 1'b1;
                  res.status      = pv2hp_pkg::ST_BAD_SIGNATURE;
                  res.addr_family = fam_ff;
               end else if (len_full == 16'd0) begin
                  res_valid = 1'b1;
                  res       = fin_rsp;
               end
            end
         end
         pv2hp_pkg::PH_PAYLOAD: begin
            if (pay_done) begin
               res_valid = 1'b1;
               res       = fin_rsp;
            end
         end
         pv2hp_pkg::PH_DATA: begin
            res_valid    = 1'b1;
            res.is_data  = 1'b1;
            res.out_byte = b;
         end
         default: begin
         end
      endcase
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pv2hp_pkg::PH_HEADER;
         cnt_ff    <= 17'd0;
         len_ff    <= 16'd0;
         cmd_ff    <= 8'd0;
         fam_ff    <= 8'd0;
         sig_ok_ff <= 1'b1;
      end else if (accept) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
         cmd_ff    <= cmd_in;
         fam_ff    <= fam_in;
         sig_ok_ff <= sig_ok_in;
      end
   end

   // kept payload bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= buf_view;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         local_is_ipv6_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready &&
                   (paddr[2] == pv2hp_pkg::CSR_LOCAL_IS_IPV6)) begin
         local_is_ipv6_ff <= pwdata[0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == pv2hp_pkg::CSR_LOCAL_IS_IPV6) ?
                   {31'd0, local_is_ipv6_ff} : 32'd0;

   // result register with skid entry
   assign req_ready = !skid_v_ff;
   assign out_free  = !out_v_ff || rsp_ready;
   assign new_res   = accept && res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff  <= skid_v_ff || new_res;
         skid_v_ff <= 1'b0;
      end else if (new_res) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end
      if (!out_free && new_res) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_is_data        = out_ff.is_data;
   assign rsp_out_byte       = out_ff.out_byte;
   assign rsp_addr_family    = out_ff.addr_family;
   assign rsp_remote_addr_hi = out_ff.remote_addr_hi;
   assign rsp_remote_addr_lo = out_ff.remote_addr_lo;
   assign rsp_local_addr_hi  = out_ff.local_addr_hi;
   assign rsp_local_addr_lo  = out_ff.local_addr_lo;
   assign rsp_remote_port    = out_ff.remote_port;
   assign rsp_local_port     = out_ff.local_port;

`ifndef ASSERT_OFF
   // skid entry only holds a result behind a waiting one
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry valid without output entry");

   // skid entry fills only while the output stalls
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid entry filled without a stalled output");

   // header counter never passes the last header byte
   a_header_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pv2hp_pkg::PH_HEADER) |-> (cnt_ff[16:4] == 13'd0))
      else $error("header byte count out of range");

   // payload phase always has bytes left to come
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pv2hp_pkg::PH_PAYLOAD) |-> ((len_ff != 16'd0) && (cnt_ff < {1'b0, len_ff})))
      else $error("payload phase with no bytes left");
`endif

endmodule

// ===== test/proxy_v2_header_parser_tb.sv =====
`timescale 1ns / 1ps

module proxy_v2_header_parser_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_CYCLES = 300;
   localparam logic [0:11][7:0] PREAMBLE = {
      8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D, 8'h0A, 8'h51, 8'h55, 8'h49, 8'h54, 8'h0A
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_first_of_connection;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_is_data;
   logic [7:0]  rsp_out_byte;
   logic [7:0]  rsp_addr_family;
   logic [63:0] rsp_remote_addr_hi;
   logic [63:0] rsp_remote_addr_lo;
   logic [63:0] rsp_local_addr_hi;
   logic [63:0] rsp_local_addr_lo;
   logic [15:0] rsp_remote_port;
   logic [15:0] rsp_local_port;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   proxy_v2_header_parser i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_data_byte           (req_data_byte),
      .req_first_of_connection (req_first_of_connection),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_is_data             (rsp_is_data),
      .rsp_out_byte            (rsp_out_byte),
      .rsp_addr_family         (rsp_addr_family),
      .rsp_remote_addr_hi      (rsp_remote_addr_hi),
      .rsp_remote_addr_lo      (rsp_remote_addr_lo),
      .rsp_local_addr_hi       (rsp_local_addr_hi),
      .rsp_local_addr_lo       (rsp_local_addr_lo),
      .rsp_remote_port         (rsp_remote_port),
      .rsp_local_port          (rsp_local_port),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   // parser mirror: per-connection state and the configured family
   logic                 ipv6_mode;
   pv2hp_pkg::phase_type parse_phase;
   logic [16:0]          phase_count;
   logic [15:0]          declared_len;
   logic [7:0]           cmd_seen;
   logic [7:0]           family_seen;
   logic                 sig_intact;
   logic [7:0]           kept_bytes [pv2hp_pkg::BUF_DEPTH];

   pv2hp_pkg::rsp_type   expected_results [$];
   int                   failures = 0;
   int                   bytes_sent = 0;
   int                   cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   stall_left = 0;
   int                   stall_asks = 0;
   int                   stall_seen = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // start of a new connection
   task automatic restart_parse();
      parse_phase = pv2hp_pkg::PH_HEADER;
      phase_count = '0;
      declared_len = '0;
      cmd_seen = '0;
      family_seen = '0;
      sig_intact = 1'b1;
      foreach (kept_bytes[i]) kept_bytes[i] = 8'h00;
   endtask

   // big-endian value from consecutive kept payload bytes
   function automatic logic [63:0] kept_word(input int first_idx, input int nbytes);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < nbytes; i++) v = (v << 8) | 64'(kept_bytes[first_idx + i]);
      return v;
   endfunction

   // end of payload: validate and build the header result
   task automatic close_header();
      pv2hp_pkg::rsp_type r;
      logic               is_v4;
      logic               is_v6;
      logic [63:0]        prefix;
      r = '0;
      r.addr_family = family_seen;
      is_v4 = family_seen inside {pv2hp_pkg::FAM_TCP4, pv2hp_pkg::FAM_UDP4};
      is_v6 = family_seen inside {pv2hp_pkg::FAM_TCP6, pv2hp_pkg::FAM_UDP6};
      prefix = ipv6_mode ? pv2hp_pkg::V4_MAPPED_PREFIX : 64'd0;
      if (cmd_seen != pv2hp_pkg::CMD_PROXY_V2) begin
         r.status = pv2hp_pkg::ST_BAD_COMMAND;
         parse_phase = pv2hp_pkg::PH_FAILED;
      end else if ((is_v4 && declared_len < pv2hp_pkg::MIN_LEN_V4) ||
                   (is_v6 && declared_len < pv2hp_pkg::MIN_LEN_V6)) begin
         r.status = pv2hp_pkg::ST_TOO_SHORT;
         parse_phase = pv2hp_pkg::PH_FAILED;
      end else begin
         r.status = pv2hp_pkg::ST_OK;
         if (is_v4) begin
            r.remote_addr_lo = prefix | kept_word(0, 4);
            r.local_addr_lo = prefix | kept_word(4, 4);
            r.remote_port = 16'(kept_word(8, 2));
            r.local_port = 16'(kept_word(10, 2));
         end else if (is_v6) begin
            // an ipv6 peer seen by an ipv4 listener keeps only its ports
            if (ipv6_mode) begin
               r.remote_addr_hi = kept_word(0, 8);
               r.remote_addr_lo = kept_word(8, 8);
               r.local_addr_hi = kept_word(16, 8);
               r.local_addr_lo = kept_word(24, 8);
            end
            r.remote_port = 16'(kept_word(32, 2));
            r.local_port = 16'(kept_word(34, 2));
         end
         parse_phase = pv2hp_pkg::PH_DATA;
         phase_count = '0;
      end
      expected_results.push_back(r);
   endtask

   // advance the mirror by one accepted byte
   task automatic parse_byte(input logic [7:0] b, input logic first);
      pv2hp_pkg::rsp_type r;
      logic [3:0]         n;
      r = '0;
      if (first) restart_parse();
      case (parse_phase)
         pv2hp_pkg::PH_HEADER: begin
            n = phase_count[3:0];
            if (n < pv2hp_pkg::SIG_LEN) begin
               if (b != PREAMBLE[n]) sig_intact = 1'b0;
            end else if (n == pv2hp_pkg::CMD_IDX) begin
               cmd_seen = b;
            end else if (n == pv2hp_pkg::FAM_IDX) begin
               family_seen = b;
            end else if (n == pv2hp_pkg::LEN_HI_IDX) begin
               declared_len = {b, 8'h00};
            end else begin
               declared_len = declared_len | {8'h00, b};
            end
            phase_count = 17'(n) + 17'd1;
            if (n == pv2hp_pkg::HDR_LAST) begin
               // signature errors surface only once the fixed header is complete
               if (!sig_intact) begin
                  r.status = pv2hp_pkg::ST_BAD_SIGNATURE;
                  r.addr_family = family_seen;
                  parse_phase = pv2hp_pkg::PH_FAILED;
                  expected_results.push_back(r);
               end else begin
                  phase_count = '0;
                  if (declared_len == 16'd0) close_header();
                  else parse_phase = pv2hp_pkg::PH_PAYLOAD;
               end
            end
         end
         pv2hp_pkg::PH_PAYLOAD: begin
            if (phase_count < pv2hp_pkg::BUF_DEPTH) kept_bytes[phase_count] = b;
            phase_count = phase_count + 17'd1;
            if (phase_count >= {1'b0, declared_len}) close_header();
         end
         pv2hp_pkg::PH_DATA: begin
            r.is_data = 1'b1;
            r.out_byte = b;
            expected_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   // one byte transfer on the input channel, called at a rising edge
   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_first_of_connection <= first;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      parse_byte(b, first);
      bytes_sent++;
   endtask

   // drop valid and let every expected result arrive
   task automatic wait_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic check_result();
      pv2hp_pkg::rsp_type want;
      if (expected_results.size() == 0) begin
         $error("result transfer with nothing expected: is_data %0b out_byte 0x%0h",
                rsp_is_data, rsp_out_byte);
         failures++;
         return;
      end
      want = expected_results.pop_front();
      check_field("status", 64'(want.status), 64'(rsp_status));
      check_field("is_data", 64'(want.is_data), 64'(rsp_is_data));
      check_field("out_byte", 64'(want.out_byte), 64'(rsp_out_byte));
      check_field("addr_family", 64'(want.addr_family), 64'(rsp_addr_family));
      check_field("remote_addr_hi", want.remote_addr_hi, rsp_remote_addr_hi);
      check_field("remote_addr_lo", want.remote_addr_lo, rsp_remote_addr_lo);
      check_field("local_addr_hi", want.local_addr_hi, rsp_local_addr_hi);
      check_field("local_addr_lo", want.local_addr_lo, rsp_local_addr_lo);
      check_field("remote_port", 64'(want.remote_port), 64'(rsp_remote_port));
      check_field("local_port", 64'(want.local_port), 64'(rsp_local_port));
   endtask

   // result side: check each transfer, random ready, long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) check_result();
      if (stall_asks != stall_seen) begin
         stall_seen = stall_asks;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // register write followed by a read back, only while the parser is idle
   task automatic set_local_family(input logic v6);
      wait_results();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {pv2hp_pkg::CSR_LOCAL_IS_IPV6, 2'b00};
      pwdata <= {31'd0, v6};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      ipv6_mode = v6;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      check_field("local_is_ipv6", 64'(v6), 64'(prdata[0]));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // one connection: fixed header, payload, then trailing application bytes
   task automatic send_connection(input logic [7:0] cmd, input logic [7:0] fam,
                                  input logic [15:0] len, input int payload_bytes,
                                  input int data_bytes, input int bad_pos,
                                  input logic starts_connection);
      logic [7:0] b;
      for (int i = 0; i < 16; i++) begin
         if (i < pv2hp_pkg::SIG_LEN) b = PREAMBLE[i];
         else if (i == pv2hp_pkg::CMD_IDX) b = cmd;
         else if (i == pv2hp_pkg::FAM_IDX) b = fam;
         else if (i == pv2hp_pkg::LEN_HI_IDX) b = len[15:8];
         else b = len[7:0];
         if (i == bad_pos) b = b ^ (8'h01 << $urandom_range(7));
         send_byte(b, starts_connection && i == 0);
      end
      for (int i = 0; i < payload_bytes; i++) send_byte(8'($urandom_range(255)), 1'b0);
      for (int i = 0; i < data_bytes; i++) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++)
         send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
   endtask

   // mostly well-formed connections with random content, some broken ones and noise
   task automatic random_connection();
      logic [7:0] fam;
      logic [7:0] cmd;
      int         floor_len;
      int         len;
      int         sent;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_noise($urandom_range(1, 20));
         return;
      end
      case ($urandom_range(4))
         0: fam = pv2hp_pkg::FAM_TCP4;
         1: fam = pv2hp_pkg::FAM_UDP4;
         2: fam = pv2hp_pkg::FAM_TCP6;
         3: fam = pv2hp_pkg::FAM_UDP6;
         default: fam = 8'($urandom_range(255));
      endcase
      cmd = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pv2hp_pkg::CMD_PROXY_V2;
      if (fam inside {pv2hp_pkg::FAM_TCP4, pv2hp_pkg::FAM_UDP4}) begin
         floor_len = pv2hp_pkg::MIN_LEN_V4;
      end else if (fam inside {pv2hp_pkg::FAM_TCP6, pv2hp_pkg::FAM_UDP6}) begin
         floor_len = pv2hp_pkg::MIN_LEN_V6;
      end else begin
         floor_len = 0;
      end
      len = floor_len + $urandom_range(10);
      if ($urandom_range(9) == 0) len = $urandom_range(floor_len);
      sent = len;
      if (pick < 11) begin
         // huge declared length, cut short by the next connection
         len = $urandom_range(65535);
         sent = $urandom_range(40);
      end else if ($urandom_range(19) == 0) begin
         sent = $urandom_range(len);
      end
      if (sent > len) sent = len;
      send_connection(cmd, fam, 16'(len), sent, $urandom_range(12),
                      ($urandom_range(9) == 0) ? $urandom_range(11) : -1, 1'b1);
   endtask

   task automatic run_random(input int send_pct, input int recv_pct, input int count);
      int stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) random_connection();
      wait_results();
   endtask

   // header bytes arriving with no connection start flag right after reset
   task automatic test_before_start();
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP4, 16'd12, 12, 2, -1, 1'b0);
   endtask

   // every family, command and length check in the current local family
   task automatic test_header_cases();
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP4, 16'd12, 12, 3, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_UDP4, 16'd20, 20, 2, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP6, 16'd36, 36, 2, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_UDP6, 16'd50, 50, 1, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, 8'h00, 16'd0, 0, 2, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, 8'h31, 16'd16, 16, 1, -1, 1'b1);
      send_connection(8'h20, pv2hp_pkg::FAM_TCP4, 16'd12, 12, 2, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP4, 16'd11, 11, 2, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP6, 16'd35, 35, 2, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP4, 16'd12, 12, 2,
                      $urandom_range(11), 1'b1);
      send_connection(8'hFF, 8'hFF, 16'd0, 0, 2, 11, 1'b1);
      send_connection(8'hFF, 8'hFF, 16'd0, 0, 2, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP6, 16'hFFFF, 5, 0, -1, 1'b1);
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_UDP4, 16'd12, 12, 1, -1, 1'b1);
   endtask

   // payload longer than the kept bytes
   task automatic test_long_payload();
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP6, 16'd100, 100, 3, -1,
                      1'b1);
   endtask

   // result side held off while bytes keep coming, then a full drain
   task automatic test_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      stall_asks++;
      send_connection(pv2hp_pkg::CMD_PROXY_V2, pv2hp_pkg::FAM_TCP4, 16'd12, 12, 60, -1, 1'b1);
      wait_results();
      send_idle_pct = saved_pct;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_first_of_connection <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      ipv6_mode = 1'b0;
      restart_parse();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 24;
      recv_idle_pct = 61;
      test_before_start();
      set_local_family(1'b0);
      test_header_cases();
      set_local_family(1'b1);
      test_header_cases();
      test_long_payload();
      test_backpressure();

      set_local_family(1'b0);
      run_random(24, 61, 70);
      set_local_family(1'b1);
      run_random(61, 24, 70);
      set_local_family(1'b0);
      run_random(0, 0, 30);
      set_local_family(1'b1);
      run_random(0, 0, 30);

      wait_results();
      failures += expected_results.size();
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
